@@ rtl/core/hsw_pkg.sv @@
package hsw_pkg;

  // Configuration register geometry.
  localparam int WIDTH_BITS    = 7;
  localparam int DELAY_BITS    = 11;
  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd50;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 11'd960;

  // Gains are unsigned with GAIN_FRAC fraction bits and one integer bit.
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_BITS = GAIN_FRAC + 1;
  localparam int WIDTH_MAX = 100;
  localparam int PERCENT   = 100;

  typedef logic [GAIN_BITS-1:0] gain_t;
  typedef gain_t gain_lut_t [2**WIDTH_BITS];

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH = 1'b0,
    CFG_DELAY = 1'b1
  } cfg_reg_e;

  // Step strobes and read source flags from the sequencer to the datapath.
  typedef struct packed {
    logic load_x;
    logic mix;
    logic dmix;
    logic pan;
    logic bypass;
    logic hit;
  } dp_ctrl_t;

  // Mix gain for each width code; codes above the maximum act as the maximum.
  function automatic gain_lut_t build_gm_lut();
    gain_lut_t lut;
    int p;
    for (int i = 0; i < 2**WIDTH_BITS; i++) begin
      p = (i > WIDTH_MAX) ? WIDTH_MAX : i;
      lut[i] = GAIN_BITS'((p * (1 << GAIN_FRAC) + PERCENT / 2) / PERCENT);
    end
    return lut;
  endfunction

  // Pan gain (1+w)/2 for each width code.
  function automatic gain_lut_t build_gp_lut();
    gain_lut_t lut;
    int p;
    for (int i = 0; i < 2**WIDTH_BITS; i++) begin
      p = (i > WIDTH_MAX) ? WIDTH_MAX : i;
      lut[i] = GAIN_BITS'(((PERCENT + p) * (1 << (GAIN_FRAC - 1)) + PERCENT / 2) / PERCENT);
    end
    return lut;
  endfunction

  localparam gain_lut_t GM_LUT = build_gm_lut();
  localparam gain_lut_t GP_LUT = build_gp_lut();

endpackage

@@ rtl/core/hsw_mono_if.sv @@
interface hsw_mono_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mono_sample;

  modport source (output valid, output mono_sample, input ready);
  modport sink (input valid, input mono_sample, output ready);
endinterface

@@ rtl/core/hsw_stereo_if.sv @@
interface hsw_stereo_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

@@ rtl/core/hsw_delay_mem.sv @@
module hsw_delay_mem #(
  parameter int DEPTH       = 2048,
  parameter int ADDR_BITS   = 11,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ADDR_BITS-1:0]   waddr_i,
  input  logic [SAMPLE_BITS-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [ADDR_BITS-1:0]   raddr_i,
  output logic [SAMPLE_BITS-1:0] rdata_o
);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/hsw_mix.sv @@
module hsw_mix #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  hsw_pkg::dp_ctrl_t                    ctrl_i,
  input  logic [hsw_pkg::WIDTH_BITS-1:0]       width_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic [SAMPLE_BITS-1:0]               rdata_i,
  output logic signed [SAMPLE_BITS-1:0]        left_o,
  output logic signed [SAMPLE_BITS-1:0]        right_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int GF = hsw_pkg::GAIN_FRAC;
  localparam int GB = hsw_pkg::GAIN_BITS;
  localparam int PW = SB + GB + 2;
  localparam int SW = PW + 1;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] HALF   = {{(SW-GF){1'b0}}, 1'b1, {(GF-1){1'b0}}};

  logic signed [SB-1:0] x_q;
  logic signed [SB-1:0] d_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] prod_d;
  logic signed [SB-1:0] delayed;
  logic signed [SB:0]   diff;
  logic signed [GB:0]   gain_s;
  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] ds;
  logic signed [SW-1:0] prod_ext;
  logic signed [SW-1:0] d_sum;
  logic signed [SW-1:0] left_sum;
  logic signed [SW-1:0] right_sum;

  // Round half up at the binary point, then clamp to the sample range.
  function automatic logic signed [SB-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + HALF) >>> GF;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SB-1:0];
  endfunction

  // A weighted pair ga*a + (1-ga)*b is folded into b*1.0 + ga*(a-b), so one
  // multiplier serves both the delay mix and the pan.
  always_comb begin
    if (ctrl_i.bypass) begin
      delayed = x_q;
    end else if (ctrl_i.hit) begin
      delayed = rdata_i;
    end else begin
      delayed = '0;
    end
    if (ctrl_i.pan) begin
      gain_s = {1'b0, hsw_pkg::GP_LUT[width_i]};
      diff   = {x_q[SB-1], x_q} - {d_q[SB-1], d_q};
    end else begin
      gain_s = {1'b0, hsw_pkg::GM_LUT[width_i]};
      diff   = {delayed[SB-1], delayed} - {x_q[SB-1], x_q};
    end
    prod_d    = diff * gain_s;
    xs        = {{(SW-SB-GF){x_q[SB-1]}}, x_q, {GF{1'b0}}};
    ds        = {{(SW-SB-GF){d_q[SB-1]}}, d_q, {GF{1'b0}}};
    prod_ext  = {prod_q[PW-1], prod_q};
    d_sum     = xs + prod_ext;
    // The pan product enters left and right with opposite signs.
    left_sum  = ds + prod_ext;
    right_sum = xs - prod_ext;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= sample_i;
    end
    if (ctrl_i.mix || ctrl_i.pan) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.dmix) begin
      d_q <= round_sat(d_sum);
    end
  end

  assign left_o  = round_sat(left_sum);
  assign right_o = round_sat(right_sum);

endmodule

@@ rtl/core/haas_stereo_widener.sv @@
// Haas stereo widener.
// A mono word arrives on mono_i and a stereo word leaves on stereo_o, both
// valid/ready channels; one stereo word is produced for every mono word.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i: index 0 sets
// the width in percent (above 100 acts as 100), index 1 the delay in samples.
// Each accepted word is written into the delay RAM in the same cycle as the
// delayed word is read. Steps follow in order: the read data returns and
// the mix product forms, the mixed sample is rounded, the pan product forms,
// and the output register loads. The block accepts a new word in the cycle
// that loads the previous result and not before; the single shared multiplier
// is used twice per word, once for the mix and once for the pan.
// The output register holds a finished word while the receiver stalls; the
// next word is then held back until that register can be loaded.
// Reset clears the sequencer, the write pointer and the output valid. The
// delay RAM is not swept: a wrap flag marks entries never written since
// reset, and those read as zero, so the block is ready right after reset.
module haas_stereo_widener #(
  parameter int DELAY_DEPTH = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  hsw_mono_if.sink                           mono_i,
  hsw_stereo_if.source                       stereo_o,
  input  logic                               cfg_we_i,
  input  logic [hsw_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [hsw_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int DW = hsw_pkg::DELAY_BITS;
  localparam int CW = (AW > DW) ? AW : DW;
  localparam logic [CW-1:0] DLY_LIMIT = CW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] WP_LAST   = AW'(DELAY_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_DMIX,
    S_PAN,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [hsw_pkg::WIDTH_BITS-1:0] width_q;
  logic [DW-1:0]                  delay_q;
  logic [AW-1:0]                  wp_q, wp_d;
  logic                           wrapped_q, wrapped_d;
  logic                           bypass_q, hit_q;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0]  left_q, right_q;

  logic                           out_free;
  logic                           in_ready;
  logic                           accept;
  logic                           load_out;
  logic [CW-1:0]                  dly_ext;
  logic [AW-1:0]                  dly_a;
  logic [AW:0]                    rp_wrap;
  logic [AW-1:0]                  rp;
  logic                           bypass_d, hit_d;
  logic [SAMPLE_BITS-1:0]         rdata;
  logic signed [SAMPLE_BITS-1:0]  left_w, right_w;
  hsw_pkg::dp_ctrl_t              ctrl;

  always_comb begin
    dly_ext = CW'(delay_q);
    dly_a   = (dly_ext > DLY_LIMIT) ? DLY_LIMIT[AW-1:0] : dly_ext[AW-1:0];
    rp_wrap = {1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, dly_a};
    rp      = (wp_q >= dly_a) ? (wp_q - dly_a) : rp_wrap[AW-1:0];
    // Before the first wrap only entries up to the write pointer hold data.
    hit_d    = wrapped_q || (rp <= wp_q);
    bypass_d = (dly_a == '0);
  end

  always_comb begin
    out_free = !out_valid_q || stereo_o.ready;
    in_ready = (state_q == S_IDLE) || ((state_q == S_OUT) && out_free);
    accept   = mono_i.valid && in_ready;
    load_out = 1'b0;
    state_d  = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MIX;
        end
      end
      S_MIX:  state_d = S_DMIX;
      S_DMIX: state_d = S_PAN;
      S_PAN:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = accept ? S_MIX : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (stereo_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (accept) begin
      wp_d = (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
      if (wp_q == WP_LAST) begin
        wrapped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      bypass_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        bypass_q <= bypass_d;
        hit_q    <= hit_d;
      end
      if (load_out) begin
        left_q  <= left_w;
        right_q <= right_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= hsw_pkg::WIDTH_RESET;
      delay_q <= hsw_pkg::DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (hsw_pkg::cfg_reg_e'(cfg_idx_i))
        hsw_pkg::CFG_WIDTH: width_q <= cfg_data_i[hsw_pkg::WIDTH_BITS-1:0];
        hsw_pkg::CFG_DELAY: delay_q <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.load_x = accept;
    ctrl.mix    = (state_q == S_MIX);
    ctrl.dmix   = (state_q == S_DMIX);
    ctrl.pan    = (state_q == S_PAN);
    ctrl.bypass = bypass_q;
    ctrl.hit    = hit_q;
  end

  hsw_delay_mem #(
    .DEPTH       (DELAY_DEPTH),
    .ADDR_BITS   (AW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (mono_i.mono_sample),
    .re_i    (accept),
    .raddr_i (rp),
    .rdata_o (rdata)
  );

  hsw_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .width_i  (width_q),
    .sample_i (mono_i.mono_sample),
    .rdata_i  (rdata),
    .left_o   (left_w),
    .right_o  (right_w)
  );

  assign mono_i.ready          = in_ready;
  assign stereo_o.valid        = out_valid_q;
  assign stereo_o.left_sample  = left_q;
  assign stereo_o.right_sample = right_q;

`ifndef SYNTH
  a_accept_starts_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MIX))
    else $error("accepted word did not start the mix step");

  a_pan_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAN) |=> (state_q == S_OUT))
    else $error("pan step not followed by output step");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("output valid rose outside the output step");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("delay RAM wrap flag cleared without reset");
`endif

endmodule

@@ test/haas_stereo_widener_checker.sv @@
module haas_stereo_widener_checker #(
  parameter int DELAY_DEPTH = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hsw_mono_if                               mono,
  hsw_stereo_if                             stereo,
  input  logic                              cfg_we_i,
  input  logic [hsw_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [hsw_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output int                                mismatch_count,
  output int                                pending_count
);

  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam longint UNITY      = 64'sd65536;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  sample_t                        delay_line [DELAY_DEPTH];
  int                             wr_pos;
  logic [hsw_pkg::WIDTH_BITS-1:0] width_code;
  logic [hsw_pkg::DELAY_BITS-1:0] delay_code;
  stereo_pair_t                   stereo_want_q [$];
  int                             errors;

  // Weighted sum of two samples with Q1.16 gains, rounded half up and saturated.
  function automatic sample_t blend_q16(longint ga, longint a, longint gb, longint b);
    longint acc;
    acc = (ga * a + gb * b + 64'sd32768) >>> 16;
    if (acc > SAMPLE_MAX) begin
      acc = SAMPLE_MAX;
    end else if (acc < SAMPLE_MIN) begin
      acc = SAMPLE_MIN;
    end
    return sample_t'(acc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t      x;
    sample_t      echo;
    sample_t      mixed;
    stereo_pair_t want;
    int           pct;
    int           dly;
    int           rd_pos;
    longint       gm;
    longint       gp;
    if (!rst_ni) begin
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        delay_line[i] = '0;
      end
      wr_pos     = 0;
      width_code = 7'd50;
      delay_code = 11'd960;
      stereo_want_q.delete();
      errors     = 0;
    end else begin
      if (cfg_we_i) begin
        if (hsw_pkg::cfg_reg_e'(cfg_idx_i) == hsw_pkg::CFG_WIDTH) begin
          width_code = cfg_data_i[hsw_pkg::WIDTH_BITS-1:0];
        end else if (hsw_pkg::cfg_reg_e'(cfg_idx_i) == hsw_pkg::CFG_DELAY) begin
          delay_code = cfg_data_i[hsw_pkg::DELAY_BITS-1:0];
        end
      end

      if (stereo.valid && stereo.ready) begin
        if (stereo_want_q.size() == 0) begin
          $display("%0t: unexpected stereo word left %0d right %0d", $time,
                   stereo.left_sample, stereo.right_sample);
          errors++;
        end else begin
          want = stereo_want_q.pop_front();
          if (stereo.left_sample !== want.left) begin
            $display("%0t: left expected %0d actual %0d", $time, want.left,
                     stereo.left_sample);
            errors++;
          end
          if (stereo.right_sample !== want.right) begin
            $display("%0t: right expected %0d actual %0d", $time, want.right,
                     stereo.right_sample);
            errors++;
          end
        end
      end

      if (mono.valid && mono.ready) begin
        x   = mono.mono_sample;
        pct = (width_code > 100) ? 100 : int'(width_code);
        dly = (int'(delay_code) >= DELAY_DEPTH) ? DELAY_DEPTH - 1 : int'(delay_code);
        // The new sample goes in first, so a delay of zero reads it straight back.
        delay_line[wr_pos] = x;
        rd_pos = (wr_pos + DELAY_DEPTH - dly) % DELAY_DEPTH;
        echo   = delay_line[rd_pos];
        wr_pos = (wr_pos + 1 == DELAY_DEPTH) ? 0 : wr_pos + 1;
        gm = (longint'(pct) * UNITY + 50) / 100;
        gp = (longint'(100 + pct) * (UNITY / 2) + 50) / 100;
        mixed      = blend_q16(gm, echo, UNITY - gm, x);
        want.left  = blend_q16(gp, x, UNITY - gp, mixed);
        want.right = blend_q16(UNITY - gp, x, gp, mixed);
        stereo_want_q.push_back(want);
      end
    end
    mismatch_count <= errors;
    pending_count  <= stereo_want_q.size();
  end

endmodule

@@ test/haas_stereo_widener_tb.sv @@
module haas_stereo_widener_tb;

  localparam int SAMPLE_BITS = 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 128;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we;
  logic [hsw_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
  logic [hsw_pkg::CFG_DATA_BITS-1:0] cfg_data;
  int                                mismatch_count;
  int                                pending_count;
  int                                cycle_count = 0;
  logic                              burst_phase;
  logic                              hold_req;
  logic                              hold_done;

  hsw_mono_if #(.SAMPLE_BITS(SAMPLE_BITS)) mono_if ();
  hsw_stereo_if #(.SAMPLE_BITS(SAMPLE_BITS)) stereo_if ();

  haas_stereo_widener #(
    .DELAY_DEPTH(2048),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mono_i     (mono_if),
    .stereo_o   (stereo_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  haas_stereo_widener_checker #(
    .DELAY_DEPTH(2048),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mono           (mono_if),
    .stereo         (stereo_if),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("haas_stereo_widener regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 24'sh7FFFFF;
          1: return 24'sh800000;
          2: return 24'sh000000;
          default: return 24'shFFFFFF;
        endcase
      end
      1, 2: return sample_t'($signed($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one mono word and wait until it is taken.
  task automatic send_sample(input sample_t value, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      mono_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mono_if.valid       <= 1'b1;
    mono_if.mono_sample <= value;
    @(posedge clk_i);
    while (!mono_if.ready) @(posedge clk_i);
  endtask

  // Let the block drain completely before the registers change. The pending
  // count is registered in the checker, so it trails the last accepted word.
  task automatic drain();
    mono_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [hsw_pkg::WIDTH_BITS-1:0] width_code,
                            input logic [hsw_pkg::CFG_DATA_BITS-hsw_pkg::WIDTH_BITS-1:0] pad,
                            input logic [hsw_pkg::DELAY_BITS-1:0] delay_code);
    cfg_we   <= 1'b1;
    cfg_idx  <= hsw_pkg::CFG_WIDTH;
    cfg_data <= {pad, width_code};
    @(posedge clk_i);
    cfg_idx  <= hsw_pkg::CFG_DELAY;
    cfg_data <= delay_code;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Sink side: random stalls, one long hold-off on request, none in a burst phase.
  initial begin
    int stall;
    int run;
    hold_done = 1'b0;
    stereo_if.ready <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        stereo_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (burst_phase) begin
        stereo_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          stereo_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        stereo_if.ready <= 1'b1;
        run = $urandom_range(1, 6);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [hsw_pkg::WIDTH_BITS-1:0] width_code;
    logic [hsw_pkg::DELAY_BITS-1:0] delay_code;
    bit                             no_gap;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= hsw_pkg::CFG_WIDTH;
    cfg_data            <= '0;
    mono_if.valid       <= 1'b0;
    mono_if.mono_sample <= '0;
    burst_phase         <= 1'b0;
    hold_req            <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: half width and the long default delay.
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh000000, 1'b0);
    send_sample(24'shFFFFFF, 1'b0);
    send_sample(24'sh000001, 1'b0);
    send_sample(24'sh555555, 1'b0);
    send_sample(24'shAAAAAA, 1'b0);
    drain();

    // Full width with no delay: the current word is its own echo.
    set_config(7'd100, 4'h0, 11'd0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'shFFFFFF, 1'b0);
    send_sample(24'sh000001, 1'b0);
    drain();

    // Zero width with a one-word delay.
    set_config(7'd0, 4'hF, 11'd1);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh000005, 1'b0);
    drain();

    // Width codes above the maximum act as full width; upper data bits are ignored.
    set_config(7'd127, 4'hF, 11'd2047);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh123456, 1'b0);
    drain();
    set_config(7'd101, 4'hA, 11'd2);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'shFEDCBA, 1'b0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0: width_code = 7'd0;
        1: width_code = 7'd100;
        2: width_code = 7'($urandom_range(101, 127));
        default: width_code = 7'($urandom_range(0, 100));
      endcase
      case ($urandom_range(0, 5))
        0: delay_code = 11'd0;
        1: delay_code = 11'd2047;
        2: delay_code = 11'($urandom_range(0, 2047));
        default: delay_code = 11'($urandom_range(1, 48));
      endcase
      set_config(width_code, 4'($urandom), delay_code);
      no_gap = (phase == 4);
      burst_phase <= no_gap;
      // The sink stops for a long stretch here while words keep coming.
      if (phase == 1) begin
        hold_req <= 1'b1;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_sample(pick_sample(), no_gap);
      end
      drain();
      burst_phase <= 1'b0;
    end

    while (pending_count != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("haas_stereo_widener regression: pass");
    end else begin
      $display("haas_stereo_widener regression: fail");
    end
    $finish;
  end

endmodule

@@ haas_stereo_widener.f @@
rtl/core/hsw_pkg.sv
rtl/core/hsw_mono_if.sv
rtl/core/hsw_stereo_if.sv
rtl/core/hsw_delay_mem.sv
rtl/core/hsw_mix.sv
rtl/core/haas_stereo_widener.sv
test/haas_stereo_widener_checker.sv
test/haas_stereo_widener_tb.sv
